[rtl/sbh_pkg.sv]
// Shared types, constants and register codes for the size bin histogram unit.
// Depends on nothing; every other file in rtl imports it.
package sbh_pkg;

   localparam int MAX_EDGES_DEFAULT = 6;
   localparam int SIZE_BITS_DEFAULT = 32;

   localparam int SIZE_FIELD_BITS = 32;
   localparam int COUNT_BITS      = 32;
   localparam int BIN_BITS        = 3;
   localparam int FUNC_BITS       = 2;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int USE_BITS        = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_RECORD = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_READ   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_LAST    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGES_IN_USE = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_CEILING = 3'd7;

   typedef struct packed {
      logic [FUNC_BITS-1:0]       func;
      logic [SIZE_FIELD_BITS-1:0] item_size;
      logic [BIN_BITS-1:0]        bin_select;
   } req_payload_type;

   typedef struct packed {
      logic [BIN_BITS-1:0]        bin;
      logic [COUNT_BITS-1:0]      bin_count;
      logic [SIZE_FIELD_BITS-1:0] min_seen;
      logic [SIZE_FIELD_BITS-1:0] max_seen;
      logic [SIZE_FIELD_BITS-1:0] top_bound;
   } rsp_payload_type;

endpackage

[rtl/sbh_bin_classifier.sv]
// Bin classifier: counts the enabled edges at or below a size and finds the
// largest enabled edge. Depends on sbh_pkg.
module sbh_bin_classifier import sbh_pkg::*; #(
   parameter int MAX_EDGES = MAX_EDGES_DEFAULT,
   parameter int SIZE_W    = SIZE_BITS_DEFAULT
) (
   input  logic [SIZE_W-1:0]   edges [MAX_EDGES],
   input  logic [USE_BITS-1:0] edges_in_use,
   input  logic [SIZE_W-1:0]   size,
   output logic [BIN_BITS-1:0] bin,
   output logic [SIZE_W-1:0]   edge_hi
);

   logic [MAX_EDGES-1:0] enabled;

   always_comb begin
      for (int i = 0; i < MAX_EDGES; i++) begin
         enabled[i] = edges_in_use > USE_BITS'(i);
      end
   end

   always_comb begin
      logic [BIN_BITS-1:0] sum;
      sum = '0;
      for (int i = 0; i < MAX_EDGES; i++) begin
         sum = sum + BIN_BITS'(enabled[i] && (edges[i] <= size));
      end
      bin = sum;
   end

   always_comb begin
      logic [SIZE_W-1:0] hi;
      hi = '0;
      for (int i = 0; i < MAX_EDGES; i++) begin
         if (enabled[i] && (edges[i] > hi)) begin
            hi = edges[i];
         end
      end
      edge_hi = hi;
   end

endmodule

[rtl/size_bin_histogram_unit.sv]
// Size bin histogram unit: top level with registers, request and result stages.
// Depends on sbh_pkg and sbh_bin_classifier.
// An accepted request is registered in the request stage; its result is then registered in the result stage.
// Throughput: one request per cycle; a held result stalls requests once both stages are full.
// Reset (synchronous) zeroes all counts, sets the minimum tracker and the ceiling to all
// ones, the maximum tracker and edges to zero, with one edge in use.
module size_bin_histogram_unit import sbh_pkg::*; #(
   parameter int MAX_EDGES = MAX_EDGES_DEFAULT,
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SIZE_W   = (SIZE_BITS < SIZE_FIELD_BITS) ? SIZE_BITS : SIZE_FIELD_BITS;
   localparam int NUM_BINS = MAX_EDGES + 1;
   localparam int BIN_IDX_W = $clog2(NUM_BINS);

   logic [SIZE_W-1:0]     edge_ff [MAX_EDGES];
   logic [USE_BITS-1:0]   edges_in_use_ff;
   logic [SIZE_W-1:0]     ceiling_ff;

   logic [COUNT_BITS-1:0] count_ff [NUM_BINS];
   logic [SIZE_W-1:0]     smallest_ff;
   logic [SIZE_W-1:0]     smallest_in;
   logic [SIZE_W-1:0]     largest_ff;
   logic [SIZE_W-1:0]     largest_in;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_payload_type       s1_payload_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_payload_ff;
   rsp_payload_type       rsp_payload_in;

   logic                  req_accept;
   logic                  s1_advance;
   logic [SIZE_W-1:0]     s1_size;
   logic [BIN_BITS-1:0]   class_bin;
   logic [SIZE_W-1:0]     edge_hi;
   logic [BIN_BITS-1:0]   addr;
   logic [COUNT_BITS-1:0] count_rd;
   logic [COUNT_BITS-1:0] count_wr;
   logic                  count_we;
   logic                  clear_all;

   // Configuration registers are always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_EDGES; i++) begin
            edge_ff[i] <= '0;
         end
         edges_in_use_ff <= USE_BITS'(1);
         ceiling_ff      <= '1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index <= CSR_EDGE_LAST) begin
            for (int i = 0; i < MAX_EDGES; i++) begin
               if (csr_index == CSR_INDEX_BITS'(i)) begin
                  edge_ff[i] <= csr_data[SIZE_W-1:0];
               end
            end
         end else if (csr_index == CSR_EDGES_IN_USE) begin
            edges_in_use_ff <= csr_data[USE_BITS-1:0];
         end else if (csr_index == CSR_SIZE_CEILING) begin
            ceiling_ff <= csr_data[SIZE_W-1:0];
         end
      end
   end

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign s1_size = s1_payload_ff.item_size[SIZE_W-1:0];

   sbh_bin_classifier #(
      .MAX_EDGES (MAX_EDGES),
      .SIZE_W    (SIZE_W)
   ) u_classifier (
      .edges        (edge_ff),
      .edges_in_use (edges_in_use_ff),
      .size         (s1_size),
      .bin          (class_bin),
      .edge_hi      (edge_hi)
   );

   assign addr = (s1_payload_ff.func == FUNC_RECORD) ? class_bin : s1_payload_ff.bin_select;

   always_comb begin
      if (addr < BIN_BITS'(NUM_BINS)) begin
         count_rd = count_ff[addr[BIN_IDX_W-1:0]];
      end else begin
         count_rd = '0;
      end
   end

   always_comb begin
      count_wr       = (count_rd == '1) ? count_rd : count_rd + COUNT_BITS'(1);
      count_we       = 1'b0;
      clear_all      = 1'b0;
      smallest_in    = smallest_ff;
      largest_in     = largest_ff;
      rsp_payload_in = '0;
      unique case (s1_payload_ff.func)
         FUNC_RECORD: begin
            count_we    = 1'b1;
            smallest_in = (s1_size < smallest_ff) ? s1_size : smallest_ff;
            largest_in  = (s1_size > largest_ff) ? s1_size : largest_ff;
            rsp_payload_in.bin       = class_bin;
            rsp_payload_in.bin_count = count_wr;
         end
         FUNC_CLEAR: begin
            clear_all   = 1'b1;
            smallest_in = ceiling_ff;
            largest_in  = '0;
            rsp_payload_in.bin       = '0;
            rsp_payload_in.bin_count = '0;
         end
         default: begin
            rsp_payload_in.bin       = s1_payload_ff.bin_select;
            rsp_payload_in.bin_count = count_rd;
         end
      endcase
      rsp_payload_in.min_seen  = SIZE_FIELD_BITS'(smallest_in);
      rsp_payload_in.max_seen  = SIZE_FIELD_BITS'(largest_in);
      rsp_payload_in.top_bound = (edge_hi < largest_in) ? SIZE_FIELD_BITS'(largest_in)
                                                        : SIZE_FIELD_BITS'(ceiling_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            count_ff[i] <= '0;
         end
         smallest_ff <= '1;
         largest_ff  <= '0;
      end else if (s1_advance) begin
         smallest_ff <= smallest_in;
         largest_ff  <= largest_in;
         if (clear_all) begin
            for (int i = 0; i < NUM_BINS; i++) begin
               count_ff[i] <= '0;
            end
         end else if (count_we) begin
            count_ff[addr[BIN_IDX_W-1:0]] <= count_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_payload_ff <= req_payload;
      end
      if (s1_advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[sim/tb_size_bin_histogram_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for size_bin_histogram_unit: a directed table, then random phases.
// Results are checked by a histogram predictor or pinned values; depends on sbh_pkg and rtl.
module tb_size_bin_histogram_unit;
   import sbh_pkg::*;

   localparam int NUM_EDGES     = MAX_EDGES_DEFAULT;
   localparam int NUM_BINS      = NUM_EDGES + 1;
   localparam int RSP_LATENCY   = 2;
   localparam int SETTLE_CYCLES = 4 * RSP_LATENCY;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 150;
   localparam int CYCLE_LIMIT   = 500000;

   localparam logic [FUNC_BITS-1:0]      FUNC_SPARE = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_0 = 3'd0;
   localparam logic [31:0]               ALL_ONES   = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {ROW_REQUEST, ROW_PINNED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      req_payload_type           req;
      rsp_payload_type           rsp;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } plan_row_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data    = '0;

   logic [31:0]         edge_value [NUM_EDGES];
   logic [USE_BITS-1:0] edges_used;
   logic [31:0]         ceiling_reg;
   logic [31:0]         bin_tally [NUM_BINS];
   logic [31:0]         smallest;
   logic [31:0]         largest;

   rsp_payload_type awaited_rsp [$];
   plan_row_type    directed_plan [$];
   bit              req_pinned = 1'b0;
   rsp_payload_type pinned_rsp = '0;
   bit              no_idle    = 1'b0;
   bit              hold_rsp   = 1'b0;
   int              failures   = 0;
   int unsigned     cycle_count = 0;

   size_bin_histogram_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   function automatic rsp_payload_type tally_request(req_payload_type r);
      rsp_payload_type o;
      int unsigned     enabled;
      int unsigned     k;
      logic [31:0]     hi_edge;
      enabled     = (edges_used > NUM_EDGES) ? NUM_EDGES : edges_used;
      o.bin       = r.bin_select;
      o.bin_count = '0;
      if (r.func == FUNC_RECORD) begin
         o.bin = '0;
         for (k = 0; k < enabled; k++) begin
            if (edge_value[k] <= r.item_size) o.bin = o.bin + 1'b1;
         end
         if (bin_tally[o.bin] != ALL_ONES) bin_tally[o.bin] = bin_tally[o.bin] + 1;
         o.bin_count = bin_tally[o.bin];
         if (r.item_size > largest) largest = r.item_size;
         if (r.item_size < smallest) smallest = r.item_size;
      end else if (r.func == FUNC_CLEAR) begin
         for (k = 0; k < NUM_BINS; k++) bin_tally[k] = '0;
         smallest = ceiling_reg;
         largest  = '0;
         o.bin    = '0;
      end else if (r.bin_select < NUM_BINS) begin
         o.bin_count = bin_tally[r.bin_select];
      end
      hi_edge = '0;
      for (k = 0; k < enabled; k++) begin
         if (edge_value[k] > hi_edge) hi_edge = edge_value[k];
      end
      o.min_seen  = smallest;
      o.max_seen  = largest;
      o.top_bound = (hi_edge < largest) ? largest : ceiling_reg;
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EDGES_IN_USE: edges_used = csr_data[USE_BITS-1:0];
               CSR_SIZE_CEILING: ceiling_reg = csr_data;
               default: edge_value[csr_index] = csr_data;
            endcase
         end
         if (req_valid && req_ready) begin
            want = tally_request(req_payload);
            awaited_rsp.push_back(req_pinned ? pinned_rsp : want);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result: bin %0d count %0h", rsp_payload.bin,
                      rsp_payload.bin_count);
               failures++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("bin", 32'(want.bin), 32'(rsp_payload.bin));
               check_field("bin_count", want.bin_count, rsp_payload.bin_count);
               check_field("min_seen", want.min_seen, rsp_payload.min_seen);
               check_field("max_seen", want.max_seen, rsp_payload.max_seen);
               check_field("top_bound", want.top_bound, rsp_payload.top_bound);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** size_bin_histogram_unit: FAILED **");
         $finish;
      end
   end

   initial begin : rsp_side
      int unsigned stall;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(req_payload_type item, bit pinned, rsp_payload_type pin);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = item;
      req_pinned  = pinned;
      pinned_rsp  = pin;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      drain_results();
      csr_index = index;
      csr_data  = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_payload_type random_request(logic [31:0] span);
      req_payload_type r;
      int unsigned     pick;
      r.item_size  = $urandom();
      r.bin_select = BIN_BITS'($urandom_range(0, 7));
      pick         = $urandom_range(0, 99);
      if (pick < 70) r.func = FUNC_RECORD;
      else if (pick < 85) r.func = FUNC_READ;
      else if (pick < 93) r.func = FUNC_SPARE;
      else r.func = FUNC_CLEAR;
      if (r.func == FUNC_RECORD) begin
         case ($urandom_range(0, 5))
            0: r.item_size = $urandom();
            1: r.item_size = $urandom_range(0, 1) ? ALL_ONES : 32'd0;
            2, 3: r.item_size = edge_value[$urandom_range(0, NUM_EDGES - 1)]
                                + $urandom_range(0, 2) - 1;
            default: r.item_size = $urandom_range(0, span);
         endcase
      end
      return r;
   endfunction

   function automatic void plan_request(logic [FUNC_BITS-1:0] func, logic [31:0] size,
                                        logic [BIN_BITS-1:0] sel);
      plan_row_type row;
      row.kind           = ROW_REQUEST;
      row.req.func       = func;
      row.req.item_size  = size;
      row.req.bin_select = sel;
      row.rsp            = '0;
      row.index          = '0;
      row.data           = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_pinned(logic [FUNC_BITS-1:0] func, logic [31:0] size,
                                       logic [BIN_BITS-1:0] sel, logic [BIN_BITS-1:0] want_bin,
                                       logic [31:0] want_count, logic [31:0] want_min,
                                       logic [31:0] want_max, logic [31:0] want_top);
      plan_row_type row;
      row.kind           = ROW_PINNED;
      row.req.func       = func;
      row.req.item_size  = size;
      row.req.bin_select = sel;
      row.rsp.bin        = want_bin;
      row.rsp.bin_count  = want_count;
      row.rsp.min_seen   = want_min;
      row.rsp.max_seen   = want_max;
      row.rsp.top_bound  = want_top;
      row.index          = '0;
      row.data           = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_csr(logic [CSR_INDEX_BITS-1:0] index, logic [31:0] data);
      plan_row_type row;
      row.kind  = ROW_CSR;
      row.req   = '0;
      row.rsp   = '0;
      row.index = index;
      row.data  = data;
      directed_plan.push_back(row);
   endfunction

   initial begin
      int          phase;
      int          k;
      int unsigned use_count;
      logic [31:0] span;
      logic [31:0] pick;

      for (k = 0; k < NUM_EDGES; k++) edge_value[k] = '0;
      for (k = 0; k < NUM_BINS; k++) bin_tally[k] = '0;
      edges_used  = 3'd1;
      ceiling_reg = ALL_ONES;
      smallest    = ALL_ONES;
      largest     = '0;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      plan_pinned(FUNC_READ, 32'd0, 3'd0, 3'd0, 32'd0, ALL_ONES, 32'd0, ALL_ONES);
      plan_pinned(FUNC_RECORD, 32'd0, 3'd5, 3'd1, 32'd1, 32'd0, 32'd0, ALL_ONES);
      plan_pinned(FUNC_RECORD, ALL_ONES, 3'd2, 3'd1, 32'd2, 32'd0, ALL_ONES, ALL_ONES);
      plan_pinned(FUNC_READ, 32'h5A5A_A5A5, 3'd7, 3'd7, 32'd0, 32'd0, ALL_ONES, ALL_ONES);
      plan_pinned(FUNC_SPARE, 32'h1234_5678, 3'd1, 3'd1, 32'd2, 32'd0, ALL_ONES, ALL_ONES);
      plan_pinned(FUNC_CLEAR, ALL_ONES, 3'd6, 3'd0, 32'd0, ALL_ONES, 32'd0, ALL_ONES);
      plan_csr(CSR_EDGE_0, 32'd100);
      plan_csr(CSR_EDGE_0 + 3'd1, 32'd10);
      plan_csr(CSR_EDGE_0 + 3'd2, 32'd1000);
      plan_csr(CSR_EDGE_0 + 3'd3, ALL_ONES);
      plan_csr(CSR_EDGE_0 + 3'd4, 32'd0);
      plan_csr(CSR_EDGE_LAST, 32'd50);
      plan_csr(CSR_EDGES_IN_USE, 32'd6);
      plan_csr(CSR_SIZE_CEILING, 32'd5000);
      plan_pinned(FUNC_CLEAR, 32'd0, 3'd0, 3'd0, 32'd0, 32'd5000, 32'd0, 32'd5000);
      plan_request(FUNC_RECORD, 32'd0, 3'd0);
      plan_request(FUNC_RECORD, 32'd9, 3'd0);
      plan_request(FUNC_RECORD, 32'd10, 3'd0);
      plan_request(FUNC_RECORD, 32'd99, 3'd0);
      plan_request(FUNC_RECORD, 32'd100, 3'd0);
      plan_request(FUNC_RECORD, 32'd1000, 3'd0);
      plan_request(FUNC_RECORD, ALL_ONES - 1, 3'd0);
      plan_request(FUNC_RECORD, ALL_ONES, 3'd0);
      plan_request(FUNC_READ, 32'd0, 3'd6);
      plan_csr(CSR_EDGES_IN_USE, 32'd0);
      plan_request(FUNC_RECORD, 32'd12345, 3'd0);
      plan_csr(CSR_EDGES_IN_USE, ALL_ONES);
      plan_request(FUNC_RECORD, 32'd60, 3'd0);
      plan_request(FUNC_READ, 32'd0, 3'd3);
      plan_csr(CSR_SIZE_CEILING, 32'd0);
      plan_pinned(FUNC_CLEAR, 32'd0, 3'd0, 3'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      plan_request(FUNC_RECORD, 32'd7, 3'd0);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            write_csr(directed_plan[i].index, directed_plan[i].data);
         end else begin
            send_request(directed_plan[i].req, directed_plan[i].kind == ROW_PINNED,
                         directed_plan[i].rsp);
         end
      end

      // The result side stops for a long stretch while requests keep coming back to back.
      hold_rsp = 1'b1;
      no_idle  = 1'b1;
      for (k = 0; k < 60; k++) send_request(random_request(32'd20), 1'b0, '0);
      no_idle = 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         span = (phase % 3 == 0) ? 32'd20 : (phase % 3 == 1) ? 32'd5000 : ALL_ONES;
         for (k = 0; k < NUM_EDGES; k++) begin
            case ($urandom_range(0, 7))
               0: pick = ALL_ONES;
               1: pick = '0;
               default: pick = $urandom_range(0, span);
            endcase
            write_csr(CSR_EDGE_0 + CSR_INDEX_BITS'(k), pick);
         end
         if (phase == 0) use_count = NUM_EDGES;
         else if (phase == 1) use_count = 1;
         else use_count = $urandom_range(0, 7);
         write_csr(CSR_EDGES_IN_USE, ($urandom() & ~32'h7) | use_count);
         if (phase == 0) pick = ALL_ONES;
         else if (phase == 1) pick = '0;
         else pick = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, span);
         write_csr(CSR_SIZE_CEILING, pick);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_request(random_request(span), 1'b0, '0);
         end
         no_idle = 1'b0;
      end

      drain_results();
      if (awaited_rsp.size() != 0) begin
         $error("%0d results never arrived", awaited_rsp.size());
         failures++;
      end
      if (failures == 0) begin
         $display("** size_bin_histogram_unit: PASSED **");
      end else begin
         $display("** size_bin_histogram_unit: FAILED **");
      end
      $finish;
   end

endmodule
